[src/kps_pkg.sv]
package kps_pkg;

  // Keypad geometry and PIN size.
  localparam int ROW_COUNT     = 4;
  localparam int COLUMN_COUNT  = 3;
  localparam int PIN_LENGTH    = 4;
  localparam int INPUT_COLUMNS = 3;

  // Columns that can ever read low.
  localparam int COL_USED  = (COLUMN_COUNT < INPUT_COLUMNS) ? COLUMN_COUNT : INPUT_COLUMNS;
  // Characters that fit the packed PIN word.
  localparam int PIN_BYTES = (PIN_LENGTH < 4) ? PIN_LENGTH : 4;

  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W     = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam int PIN_W     = $clog2(PIN_LENGTH + 1);
  localparam int PIN_IDX_W = (PIN_LENGTH > 1) ? $clog2(PIN_LENGTH) : 1;

  localparam int CNT_W   = 24;
  localparam int CHAR_W  = 8;
  localparam int LEVEL_W = 3;
  localparam int ROWD_W  = 4;
  localparam int DIGIT_W = 2;
  localparam int PINC_W  = 32;

  localparam logic [CNT_W-1:0] PRESS_RESET   = 24'd4000000;
  localparam logic [CNT_W-1:0] RELEASE_RESET = 24'd400000;

  // Configuration register indexes.
  localparam logic [7:0] CFG_PRESS_IDX   = 8'd0;
  localparam logic [7:0] CFG_RELEASE_IDX = 8'd1;

  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_WAIT    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_e;

  // One result per accepted column sample.
  typedef struct packed {
    logic [ROWD_W-1:0]  row_drive;
    logic               key_valid;
    logic [CHAR_W-1:0]  key_char;
    logic [DIGIT_W-1:0] digit_number;
    logic               pin_done;
    logic [PINC_W-1:0]  pin_chars;
  } kps_result_t;

  // ASCII character of the key at a row and column; 0 outside the 4x3 pad.
  function automatic logic [CHAR_W-1:0] key_of(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
    logic [CHAR_W-1:0] ch;
    int                idx;
    ch  = '0;
    idx = int'(row) * 3 + int'(col);
    if (int'(row) < 4 && int'(col) < 3) begin
      case (idx)
        0:       ch = "1";
        1:       ch = "2";
        2:       ch = "3";
        3:       ch = "4";
        4:       ch = "5";
        5:       ch = "6";
        6:       ch = "7";
        7:       ch = "8";
        8:       ch = "9";
        9:       ch = "*";
        10:      ch = "0";
        11:      ch = "#";
        default: ch = '0;
      endcase
    end
    return ch;
  endfunction

  // Active-low one-hot row levels; rows past the fourth drive nothing low.
  function automatic logic [ROWD_W-1:0] row_drive_of(input logic [ROW_W-1:0] row);
    logic [ROWD_W-1:0] rd;
    rd = '1;
    if (int'(row) < ROWD_W) begin
      rd = ~(ROWD_W'(1) << row);
    end
    return rd;
  endfunction

endpackage

[src/keypad_scan_pin_entry.sv]
// Debounced 4x3 matrix keypad scanner with PIN entry.
//
// Each request on the slave stream carries one sample of the column lines
// and stands for one scan tick. For every accepted request the block returns
// exactly one request on the master stream: the row levels driven during that
// tick, plus the key report when a confirmed key has been released and settled,
// and the packed PIN when that key completes it.
// The configuration channel writes the press and release settle counts
// (index 0 and 1); it is always ready and should be used while idle.
// The result of an accepted sample goes straight into the output register. One
// sample is accepted every cycle unless the master side stalls; the scan step is
// a single pass of logic between the state registers and the output register.
// When the master side stalls, the output register holds its request and the
// slave side is still ready as soon as the consumer takes it in that cycle.
// Reset clears the scan to row 0, the scan phase and the PIN position, and
// loads the default settle counts of 4000000 and 400000 ticks.
module keypad_scan_pin_entry (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [2:0] column_levels
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [3:0] row_drive, [11:4] key_char,
                                     // [13:12] digit_number, [45:14] pin_chars
  output logic [1:0]  m_axis_tuser,  // [0] key_valid, [1] pin_done
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import kps_pkg::*;

  logic [CNT_W-1:0] press_q, release_q;
  logic             accept;
  kps_result_t      result;
  logic             m_valid_q;
  logic [47:0]      m_data_q;
  logic [1:0]       m_user_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Settle count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q   <= PRESS_RESET;
      release_q <= RELEASE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRESS_IDX:   press_q   <= cfg_data_i;
        CFG_RELEASE_IDX: release_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kps_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (accept),
    .levels_i        (s_axis_tdata[LEVEL_W-1:0]),
    .press_ticks_i   (press_q),
    .release_ticks_i (release_q),
    .result_o        (result)
  );

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= {2'b00, result.pin_chars, result.digit_number, result.key_char,
                   result.row_drive};
      m_user_q <= {result.pin_done, result.key_valid};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

[src/kps_core.sv]
module kps_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [kps_pkg::LEVEL_W-1:0] levels_i,
  input  logic [kps_pkg::CNT_W-1:0]   press_ticks_i,
  input  logic [kps_pkg::CNT_W-1:0]   release_ticks_i,
  output kps_pkg::kps_result_t        result_o
);
  import kps_pkg::*;

  phase_e               phase_q, phase_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     hit_q, hit_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [PIN_W-1:0]     digits_q, digits_d;
  logic [CHAR_W-1:0]    pin_store_q [PIN_LENGTH];

  logic                 found;
  logic [COL_W-1:0]     first_col;
  logic                 hit_low;
  logic                 press_wait;
  logic                 release_wait;
  logic                 report;
  logic [CHAR_W-1:0]    key_ch;
  logic [PIN_IDX_W-1:0] pos;
  logic [PIN_W-1:0]     pos_next;

  // Lowest column that reads low on the driven row.
  always_comb begin
    found     = 1'b0;
    first_col = '0;
    for (int c = COL_USED - 1; c >= 0; c--) begin
      if (!levels_i[c]) begin
        found     = 1'b1;
        first_col = COL_W'(c);
      end
    end
  end

  // The remembered column still reads low.
  always_comb begin
    hit_low = 1'b0;
    for (int c = 0; c < COL_USED; c++) begin
      if (int'(hit_q) == c && !levels_i[c]) begin
        hit_low = 1'b1;
      end
    end
  end

  assign press_wait   = cnt_q < press_ticks_i;
  assign release_wait = cnt_q < release_ticks_i;
  assign report       = (phase_q == PH_RELEASE) && !release_wait;
  assign key_ch       = key_of(row_q, hit_q);
  assign pos          = (int'(digits_q) >= PIN_LENGTH) ? '0 : PIN_IDX_W'(digits_q);
  assign pos_next     = PIN_W'(pos) + PIN_W'(1);

  // Next scan phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_SCAN: begin
        if (found) phase_d = PH_PRESS;
      end
      PH_PRESS: begin
        if (!press_wait) phase_d = hit_low ? PH_WAIT : PH_SCAN;
      end
      PH_WAIT: begin
        if (!hit_low) phase_d = PH_RELEASE;
      end
      PH_RELEASE: begin
        if (!release_wait) phase_d = PH_SCAN;
      end
      default: phase_d = PH_SCAN;
    endcase
  end

  // Counters, scan position and PIN position.
  always_comb begin
    row_d    = row_q;
    hit_d    = hit_q;
    cnt_d    = cnt_q;
    digits_d = digits_q;
    unique case (phase_q)
      PH_SCAN: begin
        if (found) begin
          hit_d = first_col;
          cnt_d = '0;
        end else if (int'(row_q) >= ROW_COUNT - 1) begin
          row_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
      PH_PRESS: begin
        cnt_d = press_wait ? cnt_q + CNT_W'(1) : '0;
      end
      PH_WAIT: begin
        if (!hit_low) cnt_d = '0;
      end
      PH_RELEASE: begin
        if (release_wait) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          cnt_d    = '0;
          row_d    = '0;
          digits_d = (int'(pos_next) >= PIN_LENGTH) ? '0 : pos_next;
        end
      end
      default: cnt_d = '0;
    endcase
  end

  // Result of this step; the new key joins the packed PIN directly.
  always_comb begin
    result_o              = '0;
    result_o.row_drive    = row_drive_of(row_q);
    if (report) begin
      result_o.key_valid    = 1'b1;
      result_o.key_char     = key_ch;
      result_o.digit_number = DIGIT_W'(pos);
      if (int'(pos_next) >= PIN_LENGTH) begin
        result_o.pin_done = 1'b1;
        for (int i = 0; i < PIN_BYTES; i++) begin
          result_o.pin_chars[8*(3-i) +: 8] = (int'(pos) == i) ? key_ch : pin_store_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SCAN;
      row_q    <= '0;
      hit_q    <= '0;
      cnt_q    <= '0;
      digits_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      row_q    <= row_d;
      hit_q    <= hit_d;
      cnt_q    <= cnt_d;
      digits_q <= digits_d;
    end
  end

  // PIN characters; each round writes every entry before it is read.
  always_ff @(posedge clk_i) begin
    if (step_i && report) begin
      pin_store_q[pos] <= key_ch;
    end
  end

endmodule

[bench/keypad_scan_pin_entry_tb.sv]
module keypad_scan_pin_entry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kps_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 300;
  localparam int STEADY_ITEMS = 60;
  localparam int HOLD_CYCLES  = 300;

  // ASCII of each key, row by row.
  localparam logic [CHAR_W-1:0] KEY_ASCII [12] = '{
    "1", "2", "3", "4", "5", "6", "7", "8", "9", "*", "0", "#"
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = '0;
  logic [23:0] cfg_data_i    = '0;

  // Scanner model state and its copy of the settle registers.
  logic [CNT_W-1:0]  press_limit   = PRESS_RESET;
  logic [CNT_W-1:0]  release_limit = RELEASE_RESET;
  logic [ROW_W-1:0]  pad_row       = '0;
  logic [COL_W-1:0]  pad_hit_col   = '0;
  phase_e            pad_phase     = PH_SCAN;
  logic [CNT_W-1:0]  settle_cnt    = '0;
  logic [PIN_W-1:0]  digit_pos     = '0;
  logic [CHAR_W-1:0] pin_store [PIN_LENGTH];

  kps_result_t expected_results [$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  items_sent  = 0;
  int  hold_req    = 0;
  bit  stall_on    = 1'b1;

  keypad_scan_pin_entry u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [2:0] column_levels
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [3:0] row_drive, [11:4] key_char,
                                     // [13:12] digit_number, [45:14] pin_chars
    .m_axis_tuser  (m_axis_tuser),   // [0] key_valid, [1] pin_done
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Cycle counter that ends a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("keypad_scan_pin_entry verification failed");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] key_ascii(input int r, input int c);
    if (r < 4 && c < 3) begin
      return KEY_ASCII[r * 3 + c];
    end
    return '0;
  endfunction

  // A column reads low only if it exists on the pad and its line is pulled down.
  function automatic bit column_pressed(input logic [LEVEL_W-1:0] lv, input int col);
    if (col >= COL_USED) begin
      return 1'b0;
    end
    return lv[col] == 1'b0;
  endfunction

  // Advances the scanner model by one tick and returns the result it produces.
  function automatic kps_result_t scan_tick(input logic [LEVEL_W-1:0] lv);
    kps_result_t res;
    int          col;
    int          pos;
    bit          found;
    logic [CHAR_W-1:0] ch;
    res = '0;
    if (int'(pad_row) >= ROW_COUNT) begin
      pad_row = '0;
    end
    res.row_drive = (int'(pad_row) < ROWD_W) ? 4'(~(4'b0001 << pad_row)) : 4'hF;
    case (pad_phase)
      PH_SCAN: begin
        found = 1'b0;
        col   = 0;
        // Walk down so that the lowest low column wins.
        for (int c = COL_USED - 1; c >= 0; c--) begin
          if (column_pressed(lv, c)) begin
            found = 1'b1;
            col   = c;
          end
        end
        if (found) begin
          pad_hit_col = COL_W'(col);
          settle_cnt  = '0;
          pad_phase   = PH_PRESS;
        end else begin
          pad_row = ROW_W'((int'(pad_row) + 1) % ROW_COUNT);
        end
      end
      PH_PRESS: begin
        if (settle_cnt < press_limit) begin
          settle_cnt = settle_cnt + 1'b1;
        end else begin
          settle_cnt = '0;
          if (column_pressed(lv, int'(pad_hit_col))) begin
            pad_phase = PH_WAIT;
          end else begin
            pad_phase = PH_SCAN;
          end
        end
      end
      PH_WAIT: begin
        if (!column_pressed(lv, int'(pad_hit_col))) begin
          settle_cnt = '0;
          pad_phase  = PH_RELEASE;
        end
      end
      default: begin
        if (settle_cnt < release_limit) begin
          settle_cnt = settle_cnt + 1'b1;
        end else begin
          ch  = key_ascii(int'(pad_row), int'(pad_hit_col));
          pos = int'(digit_pos);
          if (pos >= PIN_LENGTH) begin
            pos = 0;
          end
          pin_store[pos]   = ch;
          res.key_valid    = 1'b1;
          res.key_char     = ch;
          res.digit_number = DIGIT_W'(pos);
          pos++;
          if (pos >= PIN_LENGTH) begin
            res.pin_done = 1'b1;
            for (int i = 0; i < PIN_BYTES; i++) begin
              res.pin_chars = res.pin_chars | (32'(pin_store[i]) << (8 * (3 - i)));
            end
            pos = 0;
          end
          digit_pos  = PIN_W'(pos);
          settle_cnt = '0;
          pad_phase  = PH_SCAN;
          pad_row    = '0;
        end
      end
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string field, input logic [47:0] got,
                               input logic [47:0] want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
             field, cycle_count, got, want);
    mismatches++;
  endtask

  // Compare each delivered result with the oldest expected one.
  always @(posedge clk_i) begin
    kps_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[3:0] !== want.row_drive)
          note_mismatch("row_drive", 48'(m_axis_tdata[3:0]), 48'(want.row_drive));
        if (m_axis_tuser[0] !== want.key_valid)
          note_mismatch("key_valid", 48'(m_axis_tuser[0]), 48'(want.key_valid));
        if (m_axis_tdata[11:4] !== want.key_char)
          note_mismatch("key_char", 48'(m_axis_tdata[11:4]), 48'(want.key_char));
        if (m_axis_tdata[13:12] !== want.digit_number)
          note_mismatch("digit_number", 48'(m_axis_tdata[13:12]),
                        48'(want.digit_number));
        if (m_axis_tuser[1] !== want.pin_done)
          note_mismatch("pin_done", 48'(m_axis_tuser[1]), 48'(want.pin_done));
        if (m_axis_tdata[45:14] !== want.pin_chars)
          note_mismatch("pin_chars", 48'(m_axis_tdata[45:14]), 48'(want.pin_chars));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Sends one column sample and records the result it must cause.
  task automatic send_levels(input logic [LEVEL_W-1:0] lv);
    if (stall_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, lv};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(scan_tick(lv));
    items_sent++;
  endtask

  // Stops the sample stream and waits until every result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [7:0] idx, input logic [23:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_PRESS_IDX) begin
      press_limit = val;
    end else if (idx == CFG_RELEASE_IDX) begin
      release_limit = val;
    end
  endtask

  // Holds the given columns low on one row for a number of ticks, then lets go.
  // The columns only read low while the block drives that row.
  task automatic press_key(input int krow, input logic [LEVEL_W-1:0] lows,
                           input int hold, input int rel, input bit bounce);
    logic [LEVEL_W-1:0] lv;
    for (int i = 0; i < hold; i++) begin
      lv = (int'(pad_row) == krow) ? ~lows : 3'b111;
      if (bounce && i < 2) begin
        lv = LEVEL_W'($urandom);
      end
      send_levels(lv);
    end
    for (int i = 0; i < rel; i++) begin
      lv = 3'b111;
      if (bounce && i == 0 && $urandom_range(0, 1) == 0) begin
        lv = LEVEL_W'($urandom);
      end
      send_levels(lv);
    end
  endtask

  // A press, with bounce if asked, long enough to be confirmed and reported.
  task automatic press_full(input int krow, input int kcol, input bit bounce);
    press_key(krow, 3'b001 << kcol, 5 + int'(press_limit) + $urandom_range(0, 4),
              2 + int'(release_limit) + $urandom_range(0, 3), bounce);
  endtask

  function automatic logic [CNT_W-1:0] pick_settle();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 24'd1;
      7:       return CNT_W'($urandom_range(8, 14));
      default: return CNT_W'($urandom_range(0, 5));
    endcase
  endfunction

  // A few samples under the reset settle counts, including all columns low.
  task automatic test_reset_defaults();
    send_levels(3'b111);
    send_levels(3'b000);
    send_levels(3'b000);
    send_levels(3'b110);
  endtask

  // Zero settle counts act on the tick after each phase is entered; one PIN.
  task automatic test_zero_settle_pin();
    write_setting(CFG_PRESS_IDX, 24'd0);
    write_setting(CFG_RELEASE_IDX, 24'd0);
    press_key(0, 3'b001, 7, 2, 1'b0);
    press_key(1, 3'b010, 7, 2, 1'b0);
    press_key(2, 3'b111, 7, 2, 1'b0);
    press_key(3, 3'b100, 7, 2, 1'b0);
    press_full(3, 1, 1'b0);
  endtask

  // A press released before its settle ends goes back to scanning.
  task automatic test_unconfirmed_press();
    write_setting(CFG_PRESS_IDX, 24'd3);
    write_setting(CFG_RELEASE_IDX, 24'd2);
    press_key(1, 3'b001, 2, 6, 1'b0);
    press_key(0, 3'b110, 1, 5, 1'b0);
  endtask

  // Largest settle counts, shortened part way through each settle.
  task automatic test_settle_extremes();
    write_setting(CFG_PRESS_IDX, 24'hFFFFFF);
    write_setting(CFG_RELEASE_IDX, 24'd0);
    press_key(1, 3'b100, 40, 0, 1'b0);
    write_setting(CFG_PRESS_IDX, 24'd3);
    press_key(1, 3'b100, 4, 3, 1'b0);
    write_setting(CFG_PRESS_IDX, 24'd0);
    write_setting(CFG_RELEASE_IDX, 24'hFFFFFF);
    press_key(2, 3'b001, 6, 40, 1'b0);
    write_setting(CFG_RELEASE_IDX, 24'd1);
    press_key(0, 3'b000, 0, 4, 1'b0);
  endtask

  // Writes to indexes past the register list leave the settings alone.
  task automatic test_ignored_index();
    write_setting(8'hFF, 24'hA5A5A5);
    write_setting(8'd2, 24'h5A5A5A);
    press_full(3, 1, 1'b0);
    press_full(2, 1, 1'b0);
  endtask

  // Mostly clean presses with random keys, plus short presses, bounce and noise.
  task automatic random_sequence();
    int krow;
    int kcol;
    logic [LEVEL_W-1:0] lows;
    krow = $urandom_range(0, 3);
    kcol = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      7: press_key(krow, 3'b001 << kcol, $urandom_range(1, 3), $urandom_range(1, 4), 1'b0);
      8: begin
        repeat ($urandom_range(1, 10)) send_levels(LEVEL_W'($urandom));
      end
      9: begin
        lows = LEVEL_W'($urandom) | (3'b001 << kcol);
        press_key(krow, lows, 5 + int'(press_limit) + $urandom_range(0, 4),
                  2 + int'(release_limit) + $urandom_range(0, 3), 1'b0);
      end
      default: press_full(krow, kcol, $urandom_range(0, 2) == 0);
    endcase
  endtask

  // Several phases of random traffic, each under new settle counts.
  task automatic test_random_phases();
    int start;
    start = items_sent;
    for (int ph = 0; ph < 6; ph++) begin
      write_setting(CFG_PRESS_IDX, pick_settle());
      write_setting(CFG_RELEASE_IDX, pick_settle());
      if ($urandom_range(0, 3) == 0) begin
        write_setting(8'($urandom_range(2, 255)), 24'($urandom));
      end
      // Hold the result side off so the block fills and stalls its input.
      if (ph == 2) begin
        hold_req = HOLD_CYCLES;
      end
      while (items_sent - start < (ph + 1) * RANDOM_ITEMS / 6) begin
        random_sequence();
      end
    end
  endtask

  // Back-to-back samples with no idling on either side.
  task automatic test_steady_stream();
    int start;
    stall_on = 1'b0;
    write_setting(CFG_PRESS_IDX, 24'd2);
    write_setting(CFG_RELEASE_IDX, 24'd1);
    start = items_sent;
    while (items_sent - start < STEADY_ITEMS) begin
      press_full($urandom_range(0, 3), $urandom_range(0, 2), 1'b0);
    end
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    for (int i = 0; i < PIN_LENGTH; i++) begin
      pin_store[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_settle_pin();
    test_unconfirmed_press();
    test_settle_extremes();
    test_ignored_index();
    test_random_phases();
    test_steady_stream();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      note_mismatch("results never delivered", 48'(expected_results.size()), '0);
    end
    if (mismatches == 0) begin
      $display("keypad_scan_pin_entry verification clean");
    end else begin
      $display("keypad_scan_pin_entry verification failed");
    end
    $finish;
  end

endmodule
